### hdl/fwe_pkg.sv
// Package: shared constants and types of the frame event extractor.
package fwe_pkg;

	localparam int DEF_FRAME_BYTES    = 2048;
	localparam int DEF_EAPOL_COPY_MAX = 412;
	localparam int SSID_MAX           = 32;
	localparam int PMKID_BYTES        = 16;
	localparam int KDE_MIN_EAPOL      = 99;
	localparam int DEAUTH_RC_LEN      = 26;

	localparam logic [1:0] EV_EAPOL  = 2'd0;
	localparam logic [1:0] EV_PMKID  = 2'd1;
	localparam logic [1:0] EV_BEACON = 2'd2;
	localparam logic [1:0] EV_DEAUTH = 2'd3;

	localparam logic [1:0] CLS_MGMT = 2'd0;
	localparam logic [1:0] CLS_DATA = 2'd1;

	localparam logic [1:0] FT_MGMT = 2'd0;
	localparam logic [1:0] FT_DATA = 2'd2;
	localparam logic [3:0] ST_BEACON = 4'd8;
	localparam logic [3:0] ST_DEAUTH = 4'd12;

	localparam logic [7:0] LLC_SNAP   = 8'hAA;
	localparam logic [7:0] LLC_UI     = 8'h03;
	localparam logic [7:0] ETH_EAPOL0 = 8'h88;
	localparam logic [7:0] ETH_EAPOL1 = 8'h8E;
	localparam logic [7:0] KDE_TYPE   = 8'hDD;
	localparam logic [7:0] OUI0       = 8'h00;
	localparam logic [7:0] OUI1       = 8'h0F;
	localparam logic [7:0] OUI2       = 8'hAC;
	localparam logic [7:0] PMKID_DT   = 8'h04;

	localparam logic [1:0] CFG_CAPTURE = 2'd0;

	typedef struct packed {
		logic [1:0]  frame_class;
		logic [3:0]  channel;
		logic [7:0]  fc0;
		logic [7:0]  fc1;
		logic [47:0] a4;
		logic [47:0] a10;
		logic [47:0] a16;
		logic [7:0]  b24;
		logic [7:0]  b36;
		logic [7:0]  b37;
	} hdr_info_t;

endpackage

### hdl/fwe_if.sv
// Interfaces: frame byte input channel and event output channel.
interface fwe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [1:0] frame_class;
	logic [3:0] channel;
	logic       last_byte;

	modport source (output valid, frame_byte, frame_class, channel, last_byte, input ready);
	modport sink (input valid, frame_byte, frame_class, channel, last_byte, output ready);
endinterface

interface fwe_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [47:0] bssid;
	logic [47:0] station;
	logic [3:0]  event_channel;
	logic [2:0]  message_number;
	logic [7:0]  reason_code;
	logic [8:0]  payload_length;
	logic [63:0] payload_chunk;
	logic        event_end;
	logic        run_end;

	modport source (output valid, event_kind, bssid, station, event_channel, message_number,
		reason_code, payload_length, payload_chunk, event_end, run_end, input ready);
	modport sink (input valid, event_kind, bssid, station, event_channel, message_number,
		reason_code, payload_length, payload_chunk, event_end, run_end, output ready);
endinterface

### hdl/fwe_store.sv
// Frame store: one write port, one registered read port.
module fwe_store import fwe_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
	input  logic [7:0]                     wr_data,
	input  logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
	output logic [7:0]                     rd_data
);
	logic [7:0] mem [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

### hdl/fwe_rx.sv
// Receive side: byte counting, overflow, store writes and header field capture.
module fwe_rx import fwe_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES,
	localparam int AW = $clog2(FRAME_BYTES),
	localparam int LW = $clog2(FRAME_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	fwe_in_if.sink        in_ch,
	input  logic          capture_enable,
	input  logic          busy,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          start,
	output logic [LW-1:0] frame_len,
	output logic          frame_ovf,
	output hdr_info_t     info
);
	logic [LW-1:0] cnt_q, cnt_nxt, len_q;
	logic          ovf_q, ovf_nxt, lovf_q, start_q, room, acc;
	logic [1:0]    class_q;
	logic [3:0]    chan_q;
	logic [7:0]    fc0_q, fc1_q, b24_q, b36_q, b37_q;
	logic [47:0]   a4_q, a10_q, a16_q;

	assign in_ch.ready = !busy && !start_q;
	assign acc         = in_ch.valid && in_ch.ready;
	assign room        = cnt_q < LW'(FRAME_BYTES);
	assign cnt_nxt     = room ? cnt_q + 1'b1 : cnt_q;
	assign ovf_nxt     = ovf_q | !room;

	assign wr_en   = acc && capture_enable && room;
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_data = in_ch.frame_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			start_q <= 1'b0;
			class_q <= '0;
			chan_q  <= '0;
			len_q   <= '0;
			lovf_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (acc) begin
				if (!capture_enable) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					if (cnt_q == '0 && !ovf_q) begin
						class_q <= in_ch.frame_class;
						chan_q  <= in_ch.channel;
					end
					if (in_ch.last_byte) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						start_q <= 1'b1;
						len_q   <= cnt_nxt;
						lovf_q  <= ovf_nxt;
					end else begin
						cnt_q <= cnt_nxt;
						ovf_q <= ovf_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (cnt_q == LW'(0))  fc0_q <= in_ch.frame_byte;
			if (cnt_q == LW'(1))  fc1_q <= in_ch.frame_byte;
			if (cnt_q == LW'(24)) b24_q <= in_ch.frame_byte;
			if (cnt_q == LW'(36)) b36_q <= in_ch.frame_byte;
			if (cnt_q == LW'(37)) b37_q <= in_ch.frame_byte;
			for (int k = 0; k < 6; k++) begin
				if (cnt_q == LW'(4 + k))  a4_q[k*8 +: 8]  <= in_ch.frame_byte;
				if (cnt_q == LW'(10 + k)) a10_q[k*8 +: 8] <= in_ch.frame_byte;
				if (cnt_q == LW'(16 + k)) a16_q[k*8 +: 8] <= in_ch.frame_byte;
			end
		end
	end

	assign start     = start_q;
	assign frame_len = len_q;
	assign frame_ovf = lovf_q;

	always_comb begin
		info.frame_class = class_q;
		info.channel     = chan_q;
		info.fc0         = fc0_q;
		info.fc1         = fc1_q;
		info.a4          = a4_q;
		info.a10         = a10_q;
		info.a16         = a16_q;
		info.b24         = b24_q;
		info.b36         = b36_q;
		info.b37         = b37_q;
	end
endmodule

### hdl/fwe_parse.sv
// Parse sequencer: classifies the stored frame, searches for the PMKID KDE, emits chunks.
module fwe_parse import fwe_pkg::*; #(
	parameter int FRAME_BYTES    = DEF_FRAME_BYTES,
	parameter int EAPOL_COPY_MAX = DEF_EAPOL_COPY_MAX,
	localparam int AW = $clog2(FRAME_BYTES),
	localparam int LW = $clog2(FRAME_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [LW-1:0] frame_len,
	input  logic          frame_ovf,
	input  hdr_info_t     info,
	output logic          busy,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	fwe_out_if.source     out_ch
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_LLC    = 7'b0000100,
		S_KEY    = 7'b0001000,
		S_SRCH   = 7'b0010000,
		S_EMIT   = 7'b0100000,
		S_PUSH   = 7'b1000000
	} state_t;

	state_t        state_q;
	logic          phase_q, llc_ok_q, pmk_q, chk, match, ev_end;
	logic [AW-1:0] addr_q, pk_q;
	logic [LW-1:0] idx_q, e_q, elen_q, hdr;
	logic [2:0]    kb_q, mn;
	logic [7:0]    ki_hi_q;
	logic [7:0]    win_q [5];
	logic [63:0]   chunk_q;
	logic [1:0]    kind_q;
	logic [47:0]   bssid_q, sta_q;
	logic [3:0]    ch_q;
	logic [2:0]    mn_q;
	logic [7:0]    rc_q;
	logic [LW-1:0] plen_q;
	logic [1:0]    ftype;
	logic [3:0]    fsub;
	logic          tods, fromds;
	logic [15:0]   ki;

	logic          ov_q, oe_q, or_q;
	logic [1:0]    ok_q;
	logic [47:0]   ob_q, os_q;
	logic [3:0]    oc_q;
	logic [2:0]    om_q;
	logic [7:0]    orc_q;
	logic [8:0]    ol_q;
	logic [63:0]   ochk_q;

	assign busy    = state_q != S_IDLE;
	assign rd_addr = addr_q;

	assign ftype  = info.fc0[3:2];
	assign fsub   = info.fc0[7:4];
	assign tods   = info.fc1[0];
	assign fromds = info.fc1[1];
	assign hdr    = LW'(24) + (fsub[3] ? LW'(2) : LW'(0)) + (tods && fromds ? LW'(6) : LW'(0));
	assign ki     = {ki_hi_q, rd_data};
	assign ev_end = idx_q == plen_q;

	always_comb begin
		mn = 3'd0;
		if (!ki[8] && ki[7] && !ki[6]) mn = 3'd1;
		else if (ki[8] && !ki[7] && !ki[6] && !ki[9]) mn = 3'd2;
		else if (ki[8] && ki[7] && ki[6]) mn = 3'd3;
		else if (ki[8] && !ki[7] && !ki[6] && ki[9]) mn = 3'd4;
	end

	always_comb begin
		unique case (idx_q[2:0])
			3'd0, 3'd1: chk = rd_data == LLC_SNAP;
			3'd2:       chk = rd_data == LLC_UI;
			3'd6:       chk = rd_data == ETH_EAPOL0;
			3'd7:       chk = rd_data == ETH_EAPOL1;
			default:    chk = 1'b1;
		endcase
	end

	// window holds bytes i..i+5 with the newest byte from the store
	assign match = idx_q >= LW'(5) && win_q[0] == KDE_TYPE &&
		{1'b0, idx_q} + (LW+1)'(win_q[1]) <= {1'b0, elen_q} + (LW+1)'(3) &&
		win_q[1] >= 8'd20 && win_q[2] == OUI0 && win_q[3] == OUI1 &&
		win_q[4] == OUI2 && rd_data == PMKID_DT;

	assign out_ch.valid          = ov_q;
	assign out_ch.event_kind     = ok_q;
	assign out_ch.bssid          = ob_q;
	assign out_ch.station        = os_q;
	assign out_ch.event_channel  = oc_q;
	assign out_ch.message_number = om_q;
	assign out_ch.reason_code    = orc_q;
	assign out_ch.payload_length = ol_q;
	assign out_ch.payload_chunk  = ochk_q;
	assign out_ch.event_end      = oe_q;
	assign out_ch.run_end        = or_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
			pmk_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					phase_q <= 1'b0;
					pmk_q   <= 1'b0;
					if (start) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					if (!frame_ovf && info.frame_class <= CLS_DATA && frame_len >= LW'(24)) begin
						if (ftype == FT_MGMT && fsub == ST_BEACON) begin
							if (frame_len > LW'(38) && info.b36 == 8'h00 &&
								info.b37 <= 8'(SSID_MAX) &&
								frame_len - LW'(36) >= LW'(2) + LW'(info.b37)) begin
								state_q <= S_EMIT;
							end
						end else if (ftype == FT_MGMT && fsub == ST_DEAUTH) begin
							state_q <= S_EMIT;
						end else if (ftype == FT_DATA) begin
							if (frame_len >= hdr + LW'(12)) state_q <= S_LLC;
						end
					end
				end
				S_LLC: begin
					phase_q <= !phase_q;
					if (phase_q && idx_q[2:0] == 3'd7) begin
						if (llc_ok_q && chk && elen_q >= LW'(7)) state_q <= S_KEY;
						else state_q <= S_IDLE;
					end
				end
				S_KEY: begin
					phase_q <= !phase_q;
					if (phase_q && idx_q[0]) begin
						if (mn == 3'd0) state_q <= S_IDLE;
						else if (mn == 3'd1 && elen_q >= LW'(KDE_MIN_EAPOL)) state_q <= S_SRCH;
						else state_q <= S_EMIT;
					end
				end
				S_SRCH: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (match) pmk_q <= 1'b1;
						if (match || {1'b0, idx_q} + (LW+1)'(18) >= {1'b0, elen_q}) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (plen_q == '0) begin
						state_q <= S_PUSH;
					end else begin
						phase_q <= !phase_q;
						if (phase_q && (kb_q == 3'd7 || idx_q + 1'b1 == plen_q)) state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					phase_q <= 1'b0;
					if (!ov_q || out_ch.ready) begin
						ov_q <= 1'b1;
						if (!ev_end) state_q <= S_EMIT;
						else if (kind_q == EV_EAPOL && pmk_q) begin
							pmk_q   <= 1'b0;
							state_q <= S_EMIT;
						end else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q    <= '0;
				kb_q     <= '0;
				chunk_q  <= '0;
				llc_ok_q <= 1'b1;
			end
			S_DECIDE: begin
				ch_q   <= info.channel;
				mn_q   <= 3'd0;
				rc_q   <= 8'd0;
				addr_q <= hdr[AW-1:0];
				e_q    <= hdr + LW'(8);
				elen_q <= frame_len - hdr - LW'(8);
				if (ftype == FT_MGMT && fsub == ST_BEACON) begin
					kind_q  <= EV_BEACON;
					bssid_q <= info.a16;
					sta_q   <= '0;
					plen_q  <= LW'(info.b37);
					addr_q  <= AW'(38);
				end else begin
					kind_q  <= EV_DEAUTH;
					bssid_q <= info.a16;
					sta_q   <= info.a4;
					plen_q  <= '0;
					if (ftype == FT_MGMT && frame_len >= LW'(DEAUTH_RC_LEN)) rc_q <= info.b24;
				end
			end
			S_LLC: begin
				if (phase_q) begin
					llc_ok_q <= llc_ok_q && chk;
					if (idx_q[2:0] == 3'd7) begin
						idx_q  <= '0;
						addr_q <= e_q[AW-1:0] + AW'(5);
					end else begin
						idx_q  <= idx_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
			end
			S_KEY: begin
				if (phase_q) begin
					ki_hi_q <= rd_data;
					addr_q  <= addr_q + 1'b1;
					idx_q   <= idx_q + 1'b1;
					if (idx_q[0]) begin
						idx_q  <= '0;
						addr_q <= e_q[AW-1:0];
						kind_q <= EV_EAPOL;
						mn_q   <= mn;
						if (32'(elen_q) > 32'(EAPOL_COPY_MAX)) plen_q <= LW'(EAPOL_COPY_MAX);
						else plen_q <= elen_q;
						if (fromds && !tods) begin
							bssid_q <= info.a10;
							sta_q   <= info.a4;
						end else if (tods && !fromds) begin
							bssid_q <= info.a4;
							sta_q   <= info.a10;
						end else begin
							bssid_q <= info.a16;
							sta_q   <= info.a10;
						end
					end
				end
			end
			S_SRCH: begin
				if (phase_q) begin
					for (int k = 0; k < 4; k++) win_q[k] <= win_q[k+1];
					win_q[4] <= rd_data;
					pk_q     <= e_q[AW-1:0] + idx_q[AW-1:0] + AW'(1);
					idx_q    <= idx_q + 1'b1;
					addr_q   <= addr_q + 1'b1;
					if (match || {1'b0, idx_q} + (LW+1)'(18) >= {1'b0, elen_q}) begin
						idx_q  <= '0;
						addr_q <= e_q[AW-1:0];
					end
					if (!match) pk_q <= pk_q;
				end
			end
			S_EMIT: begin
				if (plen_q != '0 && phase_q) begin
					chunk_q[kb_q*8 +: 8] <= rd_data;
					kb_q   <= kb_q + 1'b1;
					idx_q  <= idx_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end
			S_PUSH: begin
				if (!ov_q || out_ch.ready) begin
					ok_q    <= kind_q;
					ob_q    <= bssid_q;
					os_q    <= sta_q;
					oc_q    <= ch_q;
					om_q    <= mn_q;
					orc_q   <= rc_q;
					ol_q    <= 9'(plen_q);
					ochk_q  <= chunk_q;
					oe_q    <= ev_end;
					or_q    <= ev_end && !(kind_q == EV_EAPOL && pmk_q);
					chunk_q <= '0;
					kb_q    <= '0;
					if (ev_end && kind_q == EV_EAPOL && pmk_q) begin
						kind_q <= EV_PMKID;
						ch_q   <= 4'd0;
						mn_q   <= 3'd0;
						plen_q <= LW'(PMKID_BYTES);
						idx_q  <= '0;
						addr_q <= pk_q;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

### hdl/wlan_frame_event_extractor_unit.sv
// Top level: 802.11 frame event extractor with APB configuration.
// Usage:
// in_ch carries one frame byte per transaction with class, channel and a
// last-byte flag; bytes are written to a 2048-byte store as they arrive.
// On the last byte the parse sequencer takes over and in_ch.ready drops
// until every event of the frame has been handed to the output register.
// out_ch carries events as transactions of up to 8 payload bytes each, with
// event_end on the last transaction of an event and run_end on the last of
// the frame. While receiving, frame bytes are accepted back to back. Parsing
// reads the store through its one registered read port: first the LLC check,
// then the key info, then the PMKID search over the EAPOL bytes, and last the
// payload bytes for output, gathered and handed out one chunk at a time.
// A stall on out_ch holds the sequencer at the output register; a new
// frame is accepted as soon as parsing ends, even while the final
// transaction still waits. Reset clears control state and capture_enable;
// the store needs no clearing. APB register 0 (address 0) is capture_enable.
module wlan_frame_event_extractor_unit import fwe_pkg::*; #(
	parameter int FRAME_BYTES    = DEF_FRAME_BYTES,
	parameter int EAPOL_COPY_MAX = DEF_EAPOL_COPY_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	fwe_in_if.sink      in_ch,
	fwe_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(FRAME_BYTES);
	localparam int LW = $clog2(FRAME_BYTES + 1);

	logic          cap_en_q, busy, start, ovf, wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;
	logic [LW-1:0] flen;
	hdr_info_t     info;

	assign pready = 1'b1;
	assign prdata = (paddr == CFG_CAPTURE) ? {31'd0, cap_en_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == CFG_CAPTURE) begin
			cap_en_q <= pwdata[0];
		end
	end

	fwe_rx #(.FRAME_BYTES(FRAME_BYTES)) u_rx (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .capture_enable(cap_en_q), .busy(busy),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .start(start),
		.frame_len(flen), .frame_ovf(ovf), .info(info)
	);

	fwe_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	fwe_parse #(.FRAME_BYTES(FRAME_BYTES), .EAPOL_COPY_MAX(EAPOL_COPY_MAX)) u_parse (
		.clk(clk), .arst_n(arst_n), .start(start), .frame_len(flen), .frame_ovf(ovf),
		.info(info), .busy(busy), .rd_addr(rd_addr), .rd_data(rd_data), .out_ch(out_ch)
	);
endmodule
